[hdl/mpa_pkg.sv]
// Shared types and constants for the max pooling with argmax block.
`timescale 1ns / 1ps

package mpa_pkg;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 13;
    localparam int POOL_REG_BITS   = 4;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 11;
    localparam int COUNT_REG_BITS  = 13;
    localparam int PLANE_POS_BITS  = 12;
    localparam int INDEX_BITS      = 32;

    localparam logic [COUNT_REG_BITS-1:0] PLANE_COUNT_MAX = 13'd4096;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_POOL_SIZE,
        REG_PLANE_WIDTH,
        REG_PLANE_HEIGHT,
        REG_PLANE_COUNT
    } cfg_reg_t;

    typedef struct packed {
        logic active;
        logic fresh;
        logic emit;
        logic last;
    } item_flags_t;

endpackage

[hdl/mpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mpa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/mpa_ctrl.sv]
// Position counters: window offsets, column address and flat index per request.
`timescale 1ns / 1ps

module mpa_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_POOL   = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   restart,
    input  logic                                   advance,
    input  logic [$clog2(MAX_POOL + 1)-1:0]        pool,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]       width,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0]      height,
    input  logic [mpa_pkg::COUNT_REG_BITS-1:0]     count,
    output mpa_pkg::item_flags_t                   flags,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] addr,
    output logic [mpa_pkg::INDEX_BITS-1:0]         flat
);

    localparam int PW  = $clog2(MAX_POOL + 1);
    localparam int OW  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CSW = CW + 2;
    localparam int RSW = RW + 2;
    localparam int NW  = mpa_pkg::COUNT_REG_BITS;

    logic [CW-1:0]                     col_pos_reg, col_pos_next;
    logic [CW-1:0]                     col_base_reg, col_base_next;
    logic [CW-1:0]                     out_col_reg, out_col_next;
    logic [OW-1:0]                     wco_reg, wco_next;
    logic [RW-1:0]                     row_pos_reg, row_pos_next;
    logic [RW-1:0]                     row_base_reg, row_base_next;
    logic [OW-1:0]                     wro_reg, wro_next;
    logic [mpa_pkg::PLANE_POS_BITS-1:0] plane_reg, plane_next;
    logic [mpa_pkg::INDEX_BITS-1:0]    flat_reg, flat_next;

    logic [PW-1:0] pool_m1;
    logic          col_used;
    logic          row_used;
    logic          col_wrap;
    logic          row_wrap;
    logic          col_final;
    logic          row_final;
    logic          plane_final;
    logic          row_end;
    logic          plane_end;

    always_comb
    begin
        pool_m1     = pool - PW'(1);
        col_used    = (CSW'(col_base_reg) + CSW'(pool)) <= CSW'(width);
        row_used    = (RSW'(row_base_reg) + RSW'(pool)) <= RSW'(height);
        col_wrap    = PW'(wco_reg) >= pool_m1;
        row_wrap    = PW'(wro_reg) >= pool_m1;
        col_final   = (CSW'(col_base_reg) + CSW'(pool) + CSW'(pool)) > CSW'(width);
        row_final   = (RSW'(row_base_reg) + RSW'(pool) + RSW'(pool)) > RSW'(height);
        plane_final = (NW'(plane_reg) + NW'(1)) == count;
        row_end     = (CW'(col_pos_reg + CW'(1))) >= width;
        plane_end   = (RW'(row_pos_reg + RW'(1))) >= height;

        flags.active = col_used && row_used;
        flags.fresh  = (wco_reg == '0) && (wro_reg == '0);
        flags.emit   = col_used && row_used && col_wrap && row_wrap;
        flags.last   = col_used && row_used && col_wrap && row_wrap
                       && col_final && row_final && plane_final;
        addr = out_col_reg[AW-1:0];
        flat = flat_reg;
    end

    always_comb
    begin
        col_pos_next  = col_pos_reg;
        col_base_next = col_base_reg;
        out_col_next  = out_col_reg;
        wco_next      = wco_reg;
        row_pos_next  = row_pos_reg;
        row_base_next = row_base_reg;
        wro_next      = wro_reg;
        plane_next    = plane_reg;
        flat_next     = flat_reg;
        if (restart)
        begin
            col_pos_next  = '0;
            col_base_next = '0;
            out_col_next  = '0;
            wco_next      = '0;
            row_pos_next  = '0;
            row_base_next = '0;
            wro_next      = '0;
            plane_next    = '0;
            flat_next     = '0;
        end
        else if (advance)
        begin
            flat_next = flat_reg + mpa_pkg::INDEX_BITS'(1);
            if (col_used)
            begin
                if (col_wrap)
                begin
                    wco_next      = '0;
                    out_col_next  = out_col_reg + CW'(1);
                    col_base_next = col_base_reg + CW'(pool);
                end
                else
                begin
                    wco_next = wco_reg + OW'(1);
                end
            end
            col_pos_next = col_pos_reg + CW'(1);
            if (row_end)
            begin
                col_pos_next  = '0;
                col_base_next = '0;
                out_col_next  = '0;
                wco_next      = '0;
                row_pos_next  = row_pos_reg + RW'(1);
                if (row_wrap)
                begin
                    wro_next      = '0;
                    row_base_next = row_base_reg + RW'(pool);
                end
                else
                begin
                    wro_next = wro_reg + OW'(1);
                end
                if (plane_end)
                begin
                    row_pos_next  = '0;
                    row_base_next = '0;
                    wro_next      = '0;
                    plane_next    = plane_reg + mpa_pkg::PLANE_POS_BITS'(1);
                    if (plane_final || ((NW'(plane_reg) + NW'(1)) > count))
                    begin
                        plane_next = '0;
                        flat_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            col_base_reg <= '0;
            out_col_reg  <= '0;
            wco_reg      <= '0;
            row_pos_reg  <= '0;
            row_base_reg <= '0;
            wro_reg      <= '0;
            plane_reg    <= '0;
            flat_reg     <= '0;
        end
        else
        begin
            col_pos_reg  <= col_pos_next;
            col_base_reg <= col_base_next;
            out_col_reg  <= out_col_next;
            wco_reg      <= wco_next;
            row_pos_reg  <= row_pos_next;
            row_base_reg <= row_base_next;
            wro_reg      <= wro_next;
            plane_reg    <= plane_next;
            flat_reg     <= flat_next;
        end
    end

`ifndef SYNTH
    a_col_inside: assert property (@(posedge clk) disable iff (!rst_n)
        col_pos_reg < width || col_pos_reg == '0)
        else $error("column position past plane width");
    a_base_behind: assert property (@(posedge clk) disable iff (!rst_n)
        col_base_reg <= col_pos_reg)
        else $error("window base ahead of column position");
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        flags.last |-> flags.emit && flags.active)
        else $error("final window flag without a result");
`endif

endmodule

[hdl/mpa_update.sv]
// Column partial store, compare-update with forwarding, and result register.
`timescale 1ns / 1ps

module mpa_update #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_fire,
    output logic                                   in_ready,
    input  mpa_pkg::item_flags_t                   in_flags,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] in_addr,
    input  logic [mpa_pkg::INDEX_BITS-1:0]         in_flat,
    input  logic signed [SAMPLE_BITS-1:0]          in_sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_BITS-1:0]          out_max,
    output logic [mpa_pkg::INDEX_BITS-1:0]         out_index,
    output logic                                   out_last
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW = mpa_pkg::INDEX_BITS;
    localparam int MW = SAMPLE_BITS + XW;

    logic                        s1_valid_reg, s1_valid_next;
    mpa_pkg::item_flags_t        s1_flags_reg;
    logic [AW-1:0]               s1_addr_reg;
    logic [XW-1:0]               s1_flat_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                        fwd_hit_reg;
    logic [MW-1:0]               fwd_word_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [MW-1:0]               out_word_reg;
    logic                        out_last_reg;

    logic [MW-1:0] ram_rdata;
    logic [MW-1:0] old_word;
    logic [MW-1:0] new_word;
    logic          take_new;
    logic          out_free;
    logic          s1_done;
    logic          wr_en;

    mpa_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_partials (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (new_word),
        .re    (in_fire),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        old_word = fwd_hit_reg ? fwd_word_reg : ram_rdata;
        take_new = s1_flags_reg.fresh
                   || (s1_sample_reg > $signed(old_word[SAMPLE_BITS-1:0]));
        new_word = take_new ? {s1_flat_reg, s1_sample_reg} : old_word;
        out_free = !out_valid_reg || out_ready;
        s1_done  = s1_valid_reg && (!s1_flags_reg.emit || out_free);
        wr_en    = s1_done && s1_flags_reg.active;
        in_ready = !s1_valid_reg || s1_done;

        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_done && s1_flags_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                fwd_hit_reg <= wr_en && (s1_addr_reg == in_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_flags_reg  <= in_flags;
            s1_addr_reg   <= in_addr;
            s1_flat_reg   <= in_flat;
            s1_sample_reg <= in_sample;
            fwd_word_reg  <= new_word;
        end
        if (s1_done && s1_flags_reg.emit)
        begin
            out_word_reg <= new_word;
            out_last_reg <= s1_flags_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_max   = out_word_reg[SAMPLE_BITS-1:0];
    assign out_index = out_word_reg[MW-1:SAMPLE_BITS];
    assign out_last  = out_last_reg;

`ifndef SYNTH
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_flags_reg.emit && out_valid_reg && !out_ready)
        else $error("input held off without a blocked result");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_flags_reg.emit && out_free |=> out_valid_reg)
        else $error("finished window did not reach the result register");
    a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_flags_reg.emit |-> s1_flags_reg.active)
        else $error("result from a sample outside the pooled area");
    a_no_write_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_done |=> s1_valid_reg && $stable(s1_addr_reg)
        && $stable(ram_rdata))
        else $error("held request lost its read data");
`endif

endmodule

[hdl/max_pool_with_argmax.sv]
// Top level of the streaming 2-D max pooling with argmax block.
// Usage:
//   Samples enter on sample_valid/sample_ready/sample_value in raster order:
//   planes of plane_height rows by plane_width samples, planes back to back.
//   Each request at the bottom-right sample of a pooling window produces one
//   result on result_valid/result_ready: the window maximum, the flat index
//   of its first occurrence and a flag on the tensor's final window.
//   The request closing a window passes through the stage-1 register and
//   then into the output register. Throughput: one sample per cycle while
//   sample_ready is high; the per-column partial store is a RAM with
//   registered read data, read at accept and written from stage 1, with a
//   forwarding path for back-to-back hits.
//   Stall: a result waiting in the output register blocks new samples only
//   when the next finished window needs that register.
//   Reset: counters go to the start of a tensor, registers to pool 2,
//   32 by 32, one plane. The partial store needs no clearing pass.
//   A cfg_write restarts the stream at the first sample of a tensor.
`timescale 1ns / 1ps

module max_pool_with_argmax #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_POOL    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [mpa_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [mpa_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_value,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [SAMPLE_BITS-1:0]         max_value,
    output logic [mpa_pkg::INDEX_BITS-1:0]        source_index,
    output logic                                  last_window
);

    localparam int PW = $clog2(MAX_POOL + 1);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int NW = mpa_pkg::COUNT_REG_BITS;

    localparam logic [PW-1:0] POOL_RESET   = PW'((MAX_POOL < 2) ? MAX_POOL : 2);
    localparam logic [CW-1:0] WIDTH_RESET  = CW'((MAX_WIDTH < 32) ? MAX_WIDTH : 32);
    localparam logic [RW-1:0] HEIGHT_RESET = RW'((MAX_HEIGHT < 32) ? MAX_HEIGHT : 32);

    logic [PW-1:0] pool_reg, pool_next;
    logic [CW-1:0] width_reg, width_next;
    logic [RW-1:0] height_reg, height_next;
    logic [NW-1:0] count_reg, count_next;

    logic [mpa_pkg::POOL_REG_BITS-1:0]   raw_pool;
    logic [mpa_pkg::WIDTH_REG_BITS-1:0]  raw_width;
    logic [mpa_pkg::HEIGHT_REG_BITS-1:0] raw_height;
    logic [NW-1:0]                       raw_count;

    mpa_pkg::item_flags_t           item_flags;
    logic [AW-1:0]                  item_addr;
    logic [mpa_pkg::INDEX_BITS-1:0] item_flat;
    logic                           in_fire;

    always_comb
    begin
        raw_pool    = cfg_data[mpa_pkg::POOL_REG_BITS-1:0];
        raw_width   = cfg_data[mpa_pkg::WIDTH_REG_BITS-1:0];
        raw_height  = cfg_data[mpa_pkg::HEIGHT_REG_BITS-1:0];
        raw_count   = cfg_data[NW-1:0];
        pool_next   = pool_reg;
        width_next  = width_reg;
        height_next = height_reg;
        count_next  = count_reg;
        if (cfg_write)
        begin
            unique case (mpa_pkg::cfg_reg_t'(cfg_index))
                mpa_pkg::REG_POOL_SIZE:
                begin
                    if (raw_pool == '0)
                        pool_next = PW'(1);
                    else if (32'(raw_pool) > MAX_POOL)
                        pool_next = PW'(MAX_POOL);
                    else
                        pool_next = PW'(raw_pool);
                end
                mpa_pkg::REG_PLANE_WIDTH:
                begin
                    if (raw_width == '0)
                        width_next = CW'(1);
                    else if (32'(raw_width) > MAX_WIDTH)
                        width_next = CW'(MAX_WIDTH);
                    else
                        width_next = CW'(raw_width);
                end
                mpa_pkg::REG_PLANE_HEIGHT:
                begin
                    if (raw_height == '0)
                        height_next = RW'(1);
                    else if (32'(raw_height) > MAX_HEIGHT)
                        height_next = RW'(MAX_HEIGHT);
                    else
                        height_next = RW'(raw_height);
                end
                mpa_pkg::REG_PLANE_COUNT:
                begin
                    if (raw_count == '0)
                        count_next = NW'(1);
                    else if (raw_count > mpa_pkg::PLANE_COUNT_MAX)
                        count_next = mpa_pkg::PLANE_COUNT_MAX;
                    else
                        count_next = raw_count;
                end
                default:
                begin
                    pool_next = pool_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg   <= POOL_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            count_reg  <= NW'(1);
        end
        else
        begin
            pool_reg   <= pool_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            count_reg  <= count_next;
        end
    end

    assign in_fire = sample_valid && sample_ready;

    mpa_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_POOL   (MAX_POOL)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_write),
        .advance (in_fire),
        .pool    (pool_reg),
        .width   (width_reg),
        .height  (height_reg),
        .count   (count_reg),
        .flags   (item_flags),
        .addr    (item_addr),
        .flat    (item_flat)
    );

    mpa_update #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_ready  (sample_ready),
        .in_flags  (item_flags),
        .in_addr   (item_addr),
        .in_flat   (item_flat),
        .in_sample (sample_value),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_max   (max_value),
        .out_index (source_index),
        .out_last  (last_window)
    );

endmodule

[tb/sv/tb_max_pool_with_argmax.sv]
// Self-checking testbench of max_pool_with_argmax: directed table, random configs, predictor.
`timescale 1ns / 1ps

module tb_max_pool_with_argmax;

    localparam int TB_MAX_WIDTH     = 1024;
    localparam int TB_MAX_HEIGHT    = 1024;
    localparam int TB_MAX_POOL      = 8;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS     = 600;
    localparam int RANDOM_WINDOWS   = 60;
    localparam int PHASE_ITEM_CAP   = 150;

    typedef struct packed {
        logic signed [15:0] value;
        logic [31:0]        index;
        logic               last;
    } window_result_t;

    typedef enum logic { ROW_REG, ROW_SAMPLE } row_kind_t;

    typedef struct {
        row_kind_t                         kind;
        mpa_pkg::cfg_reg_t                 reg_sel;
        logic [mpa_pkg::CFG_DATA_BITS-1:0] reg_data;
        logic signed [15:0]                sample;
        bit                                typed;
        window_result_t                    want;
    } stim_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_write;
    logic [mpa_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [mpa_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                               sample_valid;
    logic                               sample_ready;
    logic signed [15:0]                 sample_value;
    logic                               result_valid;
    logic                               result_ready;
    logic signed [15:0]                 max_value;
    logic [mpa_pkg::INDEX_BITS-1:0]     source_index;
    logic                               last_window;

    max_pool_with_argmax u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .max_value    (max_value),
        .source_index (source_index),
        .last_window  (last_window)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [mpa_pkg::POOL_REG_BITS-1:0]   pool_reg;
    logic [mpa_pkg::WIDTH_REG_BITS-1:0]  width_reg;
    logic [mpa_pkg::HEIGHT_REG_BITS-1:0] height_reg;
    logic [mpa_pkg::COUNT_REG_BITS-1:0]  count_reg;
    logic signed [15:0]                  part_value [TB_MAX_WIDTH];
    logic [31:0]                         part_index [TB_MAX_WIDTH];
    int unsigned                         col_pos, row_pos, win_col, win_row, out_col, plane_pos;
    logic [31:0]                         flat_pos;

    window_result_t window_queue[$];
    int             mismatch_count;
    bit             idle_enable;
    bit             long_hold_req;
    bit             long_hold_done;
    int             rand_items;
    int             rand_windows;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void restart_positions();
        col_pos   = 0;
        row_pos   = 0;
        win_col   = 0;
        win_row   = 0;
        out_col   = 0;
        plane_pos = 0;
        flat_pos  = '0;
    endfunction

    function automatic void apply_reg(mpa_pkg::cfg_reg_t sel,
                                      logic [mpa_pkg::CFG_DATA_BITS-1:0] data);
        case (sel)
            mpa_pkg::REG_POOL_SIZE:    pool_reg   = data[mpa_pkg::POOL_REG_BITS-1:0];
            mpa_pkg::REG_PLANE_WIDTH:  width_reg  = data[mpa_pkg::WIDTH_REG_BITS-1:0];
            mpa_pkg::REG_PLANE_HEIGHT: height_reg = data[mpa_pkg::HEIGHT_REG_BITS-1:0];
            mpa_pkg::REG_PLANE_COUNT:  count_reg  = data[mpa_pkg::COUNT_REG_BITS-1:0];
            default: ;
        endcase
        restart_positions();
    endfunction

    function automatic bit pool_step(input logic signed [15:0] v, output window_result_t r);
        int unsigned p, w, h, n, used_w, used_h;
        bit hit;
        hit    = 1'b0;
        r      = '0;
        p      = clamp_size(pool_reg, TB_MAX_POOL);
        w      = clamp_size(width_reg, TB_MAX_WIDTH);
        h      = clamp_size(height_reg, TB_MAX_HEIGHT);
        n      = clamp_size(count_reg, mpa_pkg::PLANE_COUNT_MAX);
        used_w = (w / p) * p;
        used_h = (h / p) * p;
        if (col_pos < used_w && row_pos < used_h && out_col < TB_MAX_WIDTH)
        begin
            if ((win_col == 0 && win_row == 0) || v > part_value[out_col])
            begin
                part_value[out_col] = v;
                part_index[out_col] = flat_pos;
            end
            if (win_col == p - 1 && win_row == p - 1)
            begin
                r.value = part_value[out_col];
                r.index = part_index[out_col];
                r.last  = (plane_pos == n - 1) && (row_pos == used_h - 1) &&
                          (col_pos == used_w - 1);
                hit     = 1'b1;
            end
        end
        flat_pos = flat_pos + 1;
        if (col_pos < used_w)
        begin
            if (win_col >= p - 1)
            begin
                win_col = 0;
                out_col++;
            end
            else
                win_col++;
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            win_col = 0;
            out_col = 0;
            win_row = (win_row >= p - 1) ? 0 : win_row + 1;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
                win_row = 0;
                plane_pos++;
                if (plane_pos >= n)
                begin
                    plane_pos = 0;
                    flat_pos  = '0;
                end
            end
        end
        return hit;
    endfunction

    function automatic stim_row_t row_reg(mpa_pkg::cfg_reg_t sel,
                                          logic [mpa_pkg::CFG_DATA_BITS-1:0] data);
        stim_row_t row;
        row.kind     = ROW_REG;
        row.reg_sel  = sel;
        row.reg_data = data;
        row.sample   = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    function automatic stim_row_t row_sample(logic signed [15:0] v, bit typed,
                                             logic signed [15:0] want_value,
                                             logic [31:0] want_index, logic want_last);
        stim_row_t row;
        row.kind       = ROW_SAMPLE;
        row.reg_sel    = mpa_pkg::REG_POOL_SIZE;
        row.reg_data   = '0;
        row.sample     = v;
        row.typed      = typed;
        row.want.value = want_value;
        row.want.index = want_index;
        row.want.last  = want_last;
        return row;
    endfunction

    function automatic logic signed [15:0] pick_value(int mode);
        int t;
        if (mode == 1)
        begin
            t = $urandom_range(0, 6);
            return 16'(t - 3);
        end
        if (mode == 2)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh0000;
                default: return 16'($urandom);
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic write_reg(mpa_pkg::cfg_reg_t sel, logic [mpa_pkg::CFG_DATA_BITS-1:0] data);
        while (window_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_reg(sel, data);
    endtask

    task automatic set_config(logic [mpa_pkg::CFG_DATA_BITS-1:0] pd,
                              logic [mpa_pkg::CFG_DATA_BITS-1:0] wd,
                              logic [mpa_pkg::CFG_DATA_BITS-1:0] hd,
                              logic [mpa_pkg::CFG_DATA_BITS-1:0] nd);
        write_reg(mpa_pkg::REG_POOL_SIZE, pd);
        write_reg(mpa_pkg::REG_PLANE_WIDTH, wd);
        write_reg(mpa_pkg::REG_PLANE_HEIGHT, hd);
        write_reg(mpa_pkg::REG_PLANE_COUNT, nd);
    endtask

    task automatic sender_gap();
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_sample(logic signed [15:0] v, bit typed, window_result_t want,
                               output bit hit);
        window_result_t r;
        sample_valid <= 1'b1;
        sample_value <= v;
        do
            @(posedge clk);
        while (!sample_ready);
        hit = pool_step(v, r);
        if (typed)
            window_queue.push_back(want);
        else if (hit)
            window_queue.push_back(r);
    endtask

    task automatic run_phase(int items, int mode);
        bit hit;
        for (int i = 0; i < items; i++)
        begin
            sender_gap();
            send_sample(pick_value(mode), 1'b0, '0, hit);
            rand_items++;
            if (hit)
                rand_windows++;
        end
        sample_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        window_result_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            if (window_queue.size() == 0)
                report_mismatch("unexpected result", source_index, '0);
            else
            begin
                exp_r = window_queue.pop_front();
                if (max_value !== exp_r.value)
                    report_mismatch("max_value", {16'h0, max_value}, {16'h0, exp_r.value});
                if (source_index !== exp_r.index)
                    report_mismatch("source_index", source_index, exp_r.index);
                if (last_window !== exp_r.last)
                    report_mismatch("last_window", {31'h0, last_window}, {31'h0, exp_r.last});
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        result_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
                result_ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin : main_flow
        stim_row_t                         directed_rows[$];
        bit                                hit;
        logic [mpa_pkg::CFG_DATA_BITS-1:0] pd, wd, hd, nd;
        int                                tensor_items, items;

        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= mpa_pkg::REG_POOL_SIZE;
        cfg_data       <= '0;
        sample_valid   <= 1'b0;
        sample_value   <= '0;
        mismatch_count = 0;
        idle_enable    = 1'b1;
        long_hold_req  = 1'b0;
        long_hold_done = 1'b0;
        rand_items     = 0;
        rand_windows   = 0;
        pool_reg       = 4'd2;
        width_reg      = 11'd32;
        height_reg     = 11'd32;
        count_reg      = 13'd1;
        for (int i = 0; i < TB_MAX_WIDTH; i++)
        begin
            part_value[i] = '0;
            part_index[i] = '0;
        end
        restart_positions();

        // one-row plane, pool 1: extremes pass straight through
        directed_rows.push_back(row_reg(mpa_pkg::REG_POOL_SIZE, 13'd1));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_WIDTH, 13'd2));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_HEIGHT, 13'd1));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_COUNT, 13'd1));
        directed_rows.push_back(row_sample(16'sh7FFF, 1'b1, 16'sh7FFF, 32'd0, 1'b0));
        directed_rows.push_back(row_sample(16'sh8000, 1'b1, 16'sh8000, 32'd1, 1'b1));
        // pool zero acts as 1; single-sample tensor wraps index to zero
        directed_rows.push_back(row_reg(mpa_pkg::REG_POOL_SIZE, 13'd0));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_WIDTH, 13'd1));
        directed_rows.push_back(row_sample(16'sh1234, 1'b1, 16'sh1234, 32'd0, 1'b1));
        directed_rows.push_back(row_sample(-16'sd1, 1'b1, -16'sd1, 32'd0, 1'b1));
        // ties keep the earliest sample, two planes
        directed_rows.push_back(row_reg(mpa_pkg::REG_POOL_SIZE, 13'd2));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_WIDTH, 13'd2));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_HEIGHT, 13'd2));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_COUNT, 13'd2));
        directed_rows.push_back(row_sample(-16'sd5, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(row_sample(-16'sd5, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(row_sample(-16'sd5, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(row_sample(-16'sd5, 1'b1, -16'sd5, 32'd0, 1'b0));
        directed_rows.push_back(row_sample(16'sd3, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(row_sample(16'sd7, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(row_sample(16'sd7, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(row_sample(16'sd1, 1'b1, 16'sd7, 32'd5, 1'b1));
        // pool saturates to 8, larger than the plane: nothing comes out
        directed_rows.push_back(row_reg(mpa_pkg::REG_POOL_SIZE, 13'd15));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_WIDTH, 13'd1));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_HEIGHT, 13'd1));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_COUNT, 13'd1));
        directed_rows.push_back(row_sample(16'sh55AA, 1'b0, '0, '0, 1'b0));
        // pool 3 on 4 by 3: last column ignored
        directed_rows.push_back(row_reg(mpa_pkg::REG_POOL_SIZE, 13'd3));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_WIDTH, 13'd4));
        directed_rows.push_back(row_reg(mpa_pkg::REG_PLANE_HEIGHT, 13'd3));
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (r == 2 && c == 2)
                    directed_rows.push_back(row_sample(16'sd9, 1'b1, 16'sd9, 32'd10, 1'b1));
                else
                    directed_rows.push_back(row_sample(16'(r * 3 + c + 1), 1'b0,
                                                       '0, '0, 1'b0));
            end
            directed_rows.push_back(row_sample(16'sd100, 1'b0, '0, '0, 1'b0));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                sample_valid <= 1'b0;
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_data);
            end
            else
            begin
                sender_gap();
                send_sample(directed_rows[i].sample, directed_rows[i].typed,
                            directed_rows[i].want, hit);
            end
        end
        sample_valid <= 1'b0;

        rand_items   = 0;
        rand_windows = 0;
        while (rand_items < RANDOM_ITEMS || rand_windows < RANDOM_WINDOWS)
        begin
            idle_enable = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: pd = 13'd0;
                1: pd = 13'($urandom_range(9, 15));
                2: pd = 13'd8;
                default: pd = 13'($urandom_range(1, 4));
            endcase
            if ($urandom_range(0, 7) == 0)
                pd = pd | (13'($urandom_range(0, 511)) << mpa_pkg::POOL_REG_BITS);
            case ($urandom_range(0, 7))
                0: wd = 13'd0;
                1: wd = 13'($urandom_range(13, 40));
                default: wd = 13'($urandom_range(1, 12));
            endcase
            if (wd > 12)
                hd = 13'($urandom_range(1, 4));
            else if ($urandom_range(0, 7) == 0)
                hd = 13'd0;
            else
                hd = 13'($urandom_range(1, 12));
            if ($urandom_range(0, 7) == 0)
                wd = wd | (13'($urandom_range(0, 3)) << mpa_pkg::WIDTH_REG_BITS);
            if ($urandom_range(0, 7) == 0)
                hd = hd | (13'($urandom_range(0, 3)) << mpa_pkg::HEIGHT_REG_BITS);
            nd = 13'($urandom_range(0, 3));
            set_config(pd, wd, hd, nd);
            tensor_items = clamp_size(width_reg, TB_MAX_WIDTH) *
                           clamp_size(height_reg, TB_MAX_HEIGHT) *
                           clamp_size(count_reg, mpa_pkg::PLANE_COUNT_MAX);
            items = tensor_items + $urandom_range(0, tensor_items);
            if (items > PHASE_ITEM_CAP)
                items = PHASE_ITEM_CAP;
            run_phase(items, $urandom_range(0, 2));
        end

        idle_enable = 1'b1;
        set_config(13'd8, 13'd8, 13'd8, 13'd2);
        run_phase(128, 0);

        // width saturates to 1024; long result hold-off backs up the input
        idle_enable = 1'b0;
        set_config(13'd1, 13'h1FFF, 13'd1, 13'd0);
        long_hold_req = 1'b1;
        run_phase(1030, 2);

        while (window_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (mismatch_count == 0 && window_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
